// File: src/tbl5d_pkg.sv
`default_nettype none
package tbl5d_pkg;

  localparam int AXIS_NODES  = 16;
  localparam int TABLE_DEPTH = 4096;
  localparam int FRAC_BITS   = 16;

  localparam int NUM_AXES  = 5;
  localparam int NUM_CORNS = 1 << NUM_AXES;
  localparam int CORN_W    = NUM_AXES;
  localparam int NODE_AW   = $clog2(AXIS_NODES);
  localparam int NODE_CW   = $clog2(AXIS_NODES + 1);
  localparam int TABLE_AW  = $clog2(TABLE_DEPTH);
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int FLAT_W    = NUM_AXES * NODE_CW + 1;
  localparam int CFG_W     = 5;
  localparam int CFG_IW    = 3;

  typedef enum logic [1:0] {
    MODE_NODE   = 2'd0,
    MODE_ENTRY  = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Per-axis locate result
  typedef struct packed {
    logic [NODE_AW-1:0] cidx;
    logic [FRAC_W-1:0]  frac;
  } loc_res_t;

  // Clamp a node count register to the legal range
  function automatic logic [NODE_CW-1:0] node_count(input logic [CFG_W-1:0] r);
    logic [NODE_CW-1:0] n;
    if (int'(r) < 2) begin
      n = NODE_CW'(2);
    end else if (int'(r) > AXIS_NODES) begin
      n = NODE_CW'(AXIS_NODES);
    end else begin
      n = NODE_CW'(r);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: src/tbl5d_if.sv
`default_nettype none
interface tbl5d_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [2:0]         axis_select;
  logic [3:0]         node_index;
  logic signed [31:0] node_value;
  logic [11:0]        entry_index;
  logic signed [31:0] entry_first;
  logic signed [31:0] entry_second;
  logic signed [31:0] query_c1;
  logic signed [31:0] query_c2;
  logic signed [31:0] query_c3;
  logic signed [31:0] query_c4;
  logic signed [31:0] query_c5;

  modport source (output valid, mode, axis_select, node_index, node_value, entry_index,
                  entry_first, entry_second, query_c1, query_c2, query_c3, query_c4,
                  query_c5, input ready);
  modport sink (input valid, mode, axis_select, node_index, node_value, entry_index,
                entry_first, entry_second, query_c1, query_c2, query_c3, query_c4,
                query_c5, output ready);
endinterface

interface tbl5d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interp_first;
  logic signed [31:0] interp_second;

  modport source (output valid, interp_first, interp_second, input ready);
  modport sink (input valid, interp_first, interp_second, output ready);
endinterface
`default_nettype wire

// File: src/tbl5d_lerp.sv
`default_nettype none
module tbl5d_lerp (
  input  wire logic                          clk,
  input  wire logic signed [31:0]            a,
  input  wire logic signed [31:0]            b,
  input  wire logic [tbl5d_pkg::FRAC_W-1:0]  t,
  output logic signed [31:0]                 y
);
  import tbl5d_pkg::*;

  localparam int PW = 33 + FRAC_W + 1;

  logic signed [32:0]     diff;
  logic signed [FRAC_W:0] ts;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   sum;
  logic signed [31:0]     a_q;

  // Register the product of the difference and the fraction
  assign diff = $signed({b[31], b}) - $signed({a[31], a});
  assign ts   = $signed({1'b0, t});
  assign prod = PW'(diff) * PW'(ts);

  always_ff @(posedge clk) begin
    a_q <= a;
  end

  logic signed [PW-1:0] prod_q;
  always_ff @(posedge clk) begin
    prod_q <= prod;
  end

  // Floor shift, add, saturate to 32 bits
  assign sum = PW'(a_q) + (prod_q >>> FRAC_BITS);

  always_comb begin
    if (sum[PW-1:31] == '0 || sum[PW-1:31] == '1) begin
      y = sum[31:0];
    end else if (sum[PW-1]) begin
      y = 32'sh8000_0000;
    end else begin
      y = 32'sh7fff_ffff;
    end
  end
endmodule
`default_nettype wire

// File: src/tbl5d_locate.sv
`default_nettype none
module tbl5d_locate (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [tbl5d_pkg::NODE_AW-1:0]  wr_addr,
  input  wire logic signed [31:0]             wr_data,
  input  wire logic                           start,
  input  wire logic signed [31:0]             coord,
  input  wire logic [tbl5d_pkg::NODE_CW-1:0]  n,
  output logic                                busy,
  output tbl5d_pkg::loc_res_t                 res
);
  import tbl5d_pkg::*;

  localparam int DCW = $clog2(FRAC_BITS + 1);

  typedef enum logic [2:0] {
    L_IDLE, L_SWEEP, L_CLASS, L_FETCH0, L_FETCH1, L_FETCH2, L_DIV
  } lstate_t;

  lstate_t              state;
  logic signed [31:0]   nmem [AXIS_NODES];
  logic signed [31:0]   rdata;
  logic [NODE_AW-1:0]   rd_addr;
  logic [NODE_CW-1:0]   k;
  logic [NODE_CW-1:0]   p;
  logic [NODE_AW-1:0]   icnt;
  logic signed [31:0]   val;
  logic signed [31:0]   lo0;
  logic signed [31:0]   last;
  logic signed [31:0]   nlo;
  logic signed [32:0]   num;
  logic signed [32:0]   den;
  logic [32:0]          rem;
  logic [32:0]          dvs;
  logic [33:0]          rem2;
  logic [FRAC_BITS-1:0] q;
  logic [DCW-1:0]       dcnt;

  assign busy = (state != L_IDLE);
  assign p    = k - NODE_CW'(1);
  assign num  = $signed({val[31], val}) - $signed({nlo[31], nlo});
  assign den  = $signed({rdata[31], rdata}) - $signed({nlo[31], nlo});
  assign rem2 = {rem, 1'b0};

  // Pick the node read address
  always_comb begin
    unique case (state)
      L_SWEEP:  rd_addr = k[NODE_AW-1:0];
      L_FETCH0: rd_addr = icnt;
      L_FETCH1: rd_addr = NODE_AW'(icnt + 1'b1);
      default:  rd_addr = '0;
    endcase
  end

  // Node store: write on load, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      nmem[wr_addr] <= wr_data;
    end
    rdata <= nmem[rd_addr];
  end

  // Sweep, clamp at the ends, fetch the cell nodes, divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            val   <= coord;
            k     <= '0;
            icnt  <= '0;
            state <= L_SWEEP;
          end
        end
        L_SWEEP: begin
          if (k != '0) begin
            if (p == '0) lo0 <= rdata;
            if (p == n - NODE_CW'(1)) last <= rdata;
            if (p != '0 && p < n - NODE_CW'(1) && rdata < val) icnt <= icnt + 1'b1;
          end
          k <= k + 1'b1;
          if (k == n) state <= L_CLASS;
        end
        L_CLASS: begin
          if (val <= lo0) begin
            res.cidx <= '0;
            res.frac <= '0;
            state    <= L_IDLE;
          end else if (val >= last) begin
            res.cidx <= NODE_AW'(n - NODE_CW'(2));
            res.frac <= FRAC_W'(1) << FRAC_BITS;
            state    <= L_IDLE;
          end else begin
            state <= L_FETCH0;
          end
        end
        L_FETCH0: state <= L_FETCH1;
        L_FETCH1: begin
          nlo   <= rdata;
          state <= L_FETCH2;
        end
        L_FETCH2: begin
          res.cidx <= icnt;
          if (num <= 0 || den <= 0) begin
            res.frac <= '0;
            state    <= L_IDLE;
          end else if (num >= den) begin
            res.frac <= FRAC_W'(1) << FRAC_BITS;
            state    <= L_IDLE;
          end else begin
            rem   <= num;
            dvs   <= den;
            q     <= '0;
            dcnt  <= DCW'(FRAC_BITS);
            state <= L_DIV;
          end
        end
        L_DIV: begin
          if (rem2 >= {1'b0, dvs}) begin
            rem <= 33'(rem2 - {1'b0, dvs});
            q   <= {q[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem <= rem2[32:0];
            q   <= {q[FRAC_BITS-2:0], 1'b0};
          end
          dcnt <= dcnt - 1'b1;
          if (dcnt == DCW'(1)) begin
            res.frac <= {1'b0, q[FRAC_BITS-2:0], (rem2 >= {1'b0, dvs})};
            state    <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/table_interp_5d_core.sv
// A lookup first locates the coordinate on every axis (a node sweep, plus a
// divide when the coordinate falls inside a cell), then sets up the base address,
// then reads the corners one at a time and merges each pair with a lerp.
// One item is in work at a time; the corner loop over the single table port
// sets throughput. A finished result waits in the output register.
// Reset (rst, synchronous) clears control and sets node counts to 2.
`default_nettype none
module table_interp_5d_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tbl5d_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [tbl5d_pkg::CFG_W-1:0]  cfg_data,
  tbl5d_in_if.sink                          req,
  tbl5d_out_if.source                       rsp
);
  import tbl5d_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOCATE, S_BASE0, S_BASE1, S_RD, S_RA, S_RDW, S_CHK, S_ADD
  } state_t;

  localparam int LVL_W = $clog2(NUM_AXES + 1);

  state_t                    state;
  logic [CFG_W-1:0]          ncfg [NUM_AXES];
  logic [NODE_CW-1:0]        ncnt [NUM_AXES];
  logic [FLAT_W-1:0]         stride [NUM_AXES];
  logic [FLAT_W-1:0]         part [NUM_AXES];
  logic [FLAT_W-1:0]         base;
  logic [FLAT_W-1:0]         addr;
  logic [FLAT_W-1:0]         addr_q;
  logic                      oob_q;
  logic [CORN_W-1:0]         c;
  logic [LVL_W-1:0]          lvl;
  logic [NUM_AXES-1:0]       lbusy;
  loc_res_t                  lres [NUM_AXES];
  logic signed [31:0]        coord [NUM_AXES];
  logic signed [31:0]        hold1 [NUM_AXES];
  logic signed [31:0]        hold2 [NUM_AXES];
  logic [NUM_AXES-1:0]       hv;
  logic signed [31:0]        cur1;
  logic signed [31:0]        cur2;
  logic signed [31:0]        y1;
  logic signed [31:0]        y2;
  logic [FRAC_W-1:0]         lt;
  logic [63:0]               tmem [TABLE_DEPTH];
  logic [63:0]               tdata;
  logic                      acc;
  logic                      lookup;
  logic                      out_load;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign lookup    = acc && (req.mode == MODE_LOOKUP);
  assign out_load  = (state == S_CHK) && (int'(lvl) == NUM_AXES) && (!rsp.valid || rsp.ready);

  assign coord[0] = req.query_c1;
  assign coord[1] = req.query_c2;
  assign coord[2] = req.query_c3;
  assign coord[3] = req.query_c4;
  assign coord[4] = req.query_c5;

  // Node count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) ncfg[i] <= CFG_W'(2);
    end else if (cfg_we && int'(cfg_index) < NUM_AXES) begin
      ncfg[cfg_index] <= cfg_data;
    end
  end

  // Strides: one multiply per stage, registered along the chain from the last axis
  always_ff @(posedge clk) begin
    stride[NUM_AXES-1] <= FLAT_W'(1);
    for (int i = NUM_AXES - 2; i >= 0; i--) begin
      stride[i] <= FLAT_W'(stride[i+1] * ncnt[i+1]);
    end
  end

  // Per-axis locate lanes
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    assign ncnt[g] = node_count(ncfg[g]);
    tbl5d_locate u_loc (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (acc && req.mode == MODE_NODE && int'(req.axis_select) == g
                && int'(req.node_index) < AXIS_NODES),
      .wr_addr (NODE_AW'(req.node_index)),
      .wr_data (req.node_value),
      .start   (lookup),
      .coord   (coord[g]),
      .n       (ncnt[g]),
      .busy    (lbusy[g]),
      .res     (lres[g])
    );
  end

  // Corner address: base plus the strides picked by the corner bits
  always_comb begin
    addr = base;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (c[NUM_AXES-1-i]) addr = addr + stride[i];
    end
  end

  // Table store: write on load, registered read
  always_ff @(posedge clk) begin
    if (acc && req.mode == MODE_ENTRY && int'(req.entry_index) < TABLE_DEPTH) begin
      tmem[TABLE_AW'(req.entry_index)] <= {req.entry_second, req.entry_first};
    end
    tdata <= tmem[addr_q[TABLE_AW-1:0]];
  end

  // Merge stage: lerp units for both values
  assign lt = lres[NUM_AXES-1-int'(lvl)].frac;

  tbl5d_lerp u_lerp1 (.clk(clk), .a(hold1[lvl]), .b(cur1), .t(lt), .y(y1));
  tbl5d_lerp u_lerp2 (.clk(clk), .a(hold2[lvl]), .b(cur2), .t(lt), .y(y2));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      hv        <= '0;
      lvl       <= '0;
    end else begin
      // Raise valid on a new result, drop it once the beat is taken
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (lookup) state <= S_LOCATE;
        end
        S_LOCATE: begin
          if (lbusy == '0) state <= S_BASE0;
        end
        S_BASE0: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            part[i] <= FLAT_W'(lres[i].cidx * stride[i]);
          end
          hv    <= '0;
          c     <= '0;
          state <= S_BASE1;
        end
        S_BASE1: begin
          base  <= part[0] + part[1] + part[2] + part[3] + part[4];
          state <= S_RD;
        end
        S_RD: begin
          addr_q <= addr;
          oob_q  <= (addr >= FLAT_W'(TABLE_DEPTH));
          state  <= S_RA;
        end
        S_RA: state <= S_RDW;
        S_RDW: begin
          cur1  <= oob_q ? 32'sd0 : tdata[31:0];
          cur2  <= oob_q ? 32'sd0 : tdata[63:32];
          lvl   <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (int'(lvl) == NUM_AXES) begin
            // Hand over the collapsed pair once the output register is free
            if (out_load) begin
              rsp.interp_first  <= cur1;
              rsp.interp_second <= cur2;
              state             <= S_IDLE;
            end
          end else if (hv[lvl]) begin
            // Combine with the held lower corner; the product registers here
            hv[lvl] <= 1'b0;
            state   <= S_ADD;
          end else begin
            hold1[lvl] <= cur1;
            hold2[lvl] <= cur2;
            hv[lvl]    <= 1'b1;
            c          <= c + 1'b1;
            state      <= S_RD;
          end
        end
        S_ADD: begin
          // Take the lerp result and move one level up
          cur1  <= y1;
          cur2  <= y2;
          lvl   <= lvl + 1'b1;
          state <= S_CHK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    int'(lvl) <= NUM_AXES) else $error("merge level out of range");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    lookup |=> !req.ready) else $error("ready during lookup");

  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_CHK)) else $error("result from wrong state");
endmodule
`default_nettype wire

// File: verif/tbl5d_checker.sv
`default_nettype none
module tbl5d_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tbl5d_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [tbl5d_pkg::CFG_W-1:0]  cfg_data,
  tbl5d_in_if                               req,
  tbl5d_out_if                              rsp,
  output int                                fail_count,
  output int                                pending
);
  import tbl5d_pkg::*;

  typedef struct {
    logic signed [31:0] first;
    logic signed [31:0] second;
  } interp_pair_t;

  localparam longint UNIT = longint'(1) << FRAC_BITS;

  interp_pair_t     interp_q[$];
  logic [CFG_W-1:0] count_reg [NUM_AXES];
  longint           node_tab  [NUM_AXES][AXIS_NODES];
  logic [63:0]      entry_tab [TABLE_DEPTH];

  initial begin
    fail_count = 0;
    pending    = 0;
    foreach (node_tab[a, k]) node_tab[a][k] = 0;
    foreach (entry_tab[k]) entry_tab[k] = '0;
  end

  function automatic int clamp_count(input logic [CFG_W-1:0] r);
    if (r < 2) return 2;
    if (r > AXIS_NODES) return AXIS_NODES;
    return int'(r);
  endfunction

  // Linear step with floor on the product and saturation to 32 bits
  function automatic longint lerp_fix(input longint a, input longint b, input longint t);
    longint v;
    v = a + (((b - a) * t) >>> FRAC_BITS);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  // Locate every axis, fetch the 32 corners and collapse axis five first
  function automatic interp_pair_t interpolate(input longint q [NUM_AXES]);
    int           n    [NUM_AXES];
    int           cidx [NUM_AXES];
    longint       frac [NUM_AXES];
    longint       v1   [NUM_CORNS];
    longint       v2   [NUM_CORNS];
    longint       addr, num, den;
    logic [63:0]  e;
    int           i, len;
    interp_pair_t r;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      n[ax] = clamp_count(count_reg[ax]);
      if (q[ax] <= node_tab[ax][0]) begin
        cidx[ax] = 0;
        frac[ax] = 0;
      end else if (q[ax] >= node_tab[ax][n[ax]-1]) begin
        cidx[ax] = n[ax] - 2;
        frac[ax] = UNIT;
      end else begin
        i = 0;
        for (int j = 1; j + 1 < n[ax]; j++)
          if (node_tab[ax][j] < q[ax]) i++;
        num = q[ax] - node_tab[ax][i];
        den = node_tab[ax][i+1] - node_tab[ax][i];
        if (num <= 0 || den <= 0) begin
          frac[ax] = 0;
        end else begin
          frac[ax] = (num <<< FRAC_BITS) / den;
          if (frac[ax] > UNIT) frac[ax] = UNIT;
        end
        cidx[ax] = i;
      end
    end
    for (int c = 0; c < NUM_CORNS; c++) begin
      addr = 0;
      for (int ax = 0; ax < NUM_AXES; ax++)
        addr = addr * n[ax] + cidx[ax] + ((c >> (NUM_AXES - 1 - ax)) & 1);
      e = (addr < TABLE_DEPTH) ? entry_tab[addr] : 64'd0;
      v1[c] = $signed(e[31:0]);
      v2[c] = $signed(e[63:32]);
    end
    len = NUM_CORNS;
    for (int ax = NUM_AXES - 1; ax >= 0; ax--) begin
      len = len >> 1;
      for (int c = 0; c < len; c++) begin
        v1[c] = lerp_fix(v1[2*c], v1[2*c+1], frac[ax]);
        v2[c] = lerp_fix(v2[2*c], v2[2*c+1], frac[ax]);
      end
    end
    r.first  = v1[0][31:0];
    r.second = v2[0][31:0];
    return r;
  endfunction

  // Track config and loads, queue a prediction per lookup, match each result beat
  always @(posedge clk) begin
    longint       q [NUM_AXES];
    interp_pair_t want;
    if (rst) begin
      foreach (count_reg[a]) count_reg[a] = CFG_W'(2);
      interp_q.delete();
    end else begin
      if (cfg_we && cfg_index < NUM_AXES) count_reg[cfg_index] = cfg_data;
      if (req.valid && req.ready) begin
        case (mode_t'(req.mode))
          MODE_NODE: begin
            if (req.axis_select < NUM_AXES)
              node_tab[req.axis_select][req.node_index] = req.node_value;
          end
          MODE_ENTRY: begin
            entry_tab[req.entry_index] = {req.entry_second, req.entry_first};
          end
          MODE_LOOKUP: begin
            q[0] = req.query_c1;
            q[1] = req.query_c2;
            q[2] = req.query_c3;
            q[3] = req.query_c4;
            q[4] = req.query_c5;
            interp_q.push_back(interpolate(q));
          end
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (interp_q.size() == 0) begin
          $error("result beat with no lookup pending: first %0d second %0d",
                 rsp.interp_first, rsp.interp_second);
          fail_count++;
        end else begin
          want = interp_q.pop_front();
          if (rsp.interp_first !== want.first) begin
            $error("interp_first: expected %0d, got %0d", want.first, rsp.interp_first);
            fail_count++;
          end
          if (rsp.interp_second !== want.second) begin
            $error("interp_second: expected %0d, got %0d", want.second, rsp.interp_second);
            fail_count++;
          end
        end
      end
    end
    pending = interp_q.size();
  end
endmodule
`default_nettype wire

// File: verif/tb_table_interp_5d_core.sv
`default_nettype none
module tb_table_interp_5d_core;
  import tbl5d_pkg::*;

  localparam int LIMIT  = 3000000;
  localparam int SETTLE = 300;

  typedef struct {
    mode_t              mode;
    logic [2:0]         axis_select;
    logic [3:0]         node_index;
    logic signed [31:0] node_value;
    logic [11:0]        entry_index;
    logic signed [31:0] entry_first;
    logic signed [31:0] entry_second;
    logic signed [31:0] q [NUM_AXES];
  } req_item_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  int                fail_count;
  int                pending;
  int                cycles;
  bit                send_gaps;
  bit                rsp_gaps;
  bit                hold_rsp;
  longint            node_shadow [NUM_AXES][AXIS_NODES];
  int                cur_cnt [NUM_AXES];

  tbl5d_in_if  req_if ();
  tbl5d_out_if rsp_if ();

  table_interp_5d_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_if), .rsp(rsp_if)
  );

  tbl5d_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_if), .rsp(rsp_if), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[table_interp_5d_core] ERROR");
      $finish;
    end
  end

  // Result sink: random stall bursts, plus one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_if.ready = 1'b0;
        repeat (3000) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  function automatic req_item_t rand_item();
    req_item_t it;
    it.mode         = MODE_NONE;
    it.axis_select  = 3'($urandom);
    it.node_index   = 4'($urandom);
    it.node_value   = $urandom;
    it.entry_index  = 12'($urandom);
    it.entry_first  = $urandom;
    it.entry_second = $urandom;
    foreach (it.q[a]) it.q[a] = $urandom;
    return it;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Drive one request beat and hold it until accepted
  task automatic send_item(input req_item_t it);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_if.mode         = it.mode;
    req_if.axis_select  = it.axis_select;
    req_if.node_index   = it.node_index;
    req_if.node_value   = it.node_value;
    req_if.entry_index  = it.entry_index;
    req_if.entry_first  = it.entry_first;
    req_if.entry_second = it.entry_second;
    req_if.query_c1     = it.q[0];
    req_if.query_c2     = it.q[1];
    req_if.query_c3     = it.q[2];
    req_if.query_c4     = it.q[3];
    req_if.query_c5     = it.q[4];
    req_if.valid        = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic node_write(input int ax, input int ni, input longint v);
    req_item_t it;
    it = rand_item();
    it.mode        = MODE_NODE;
    it.axis_select = 3'(ax);
    it.node_index  = 4'(ni);
    it.node_value  = clip32(v);
    if (ax < NUM_AXES) node_shadow[ax][ni] = it.node_value;
    send_item(it);
  endtask

  task automatic entry_write(input int ei, input logic [31:0] f, input logic [31:0] s);
    req_item_t it;
    it = rand_item();
    it.mode         = MODE_ENTRY;
    it.entry_index  = 12'(ei);
    it.entry_first  = f;
    it.entry_second = s;
    send_item(it);
  endtask

  task automatic lookup_at(input logic signed [31:0] c [NUM_AXES]);
    req_item_t it;
    it = rand_item();
    it.mode = MODE_LOOKUP;
    it.q    = c;
    send_item(it);
  endtask

  // Hold the sender until every result is back and the block has gone quiet
  task automatic drain();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input int idx, input int val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_IW'(idx);
    cfg_data  = CFG_W'(val);
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_index = CFG_IW'($urandom);
    cfg_data  = CFG_W'($urandom);
  endtask

  task automatic set_counts(input int c0, input int c1, input int c2, input int c3,
                            input int c4);
    int c [NUM_AXES];
    c = '{c0, c1, c2, c3, c4};
    drain();
    for (int a = 0; a < NUM_AXES; a++) begin
      cfg_write(a, c[a]);
      cur_cnt[a] = (c[a] < 2) ? 2 : (c[a] > AXIS_NODES) ? AXIS_NODES : c[a];
    end
  endtask

  // Load ascending nodes; noise inserts flat or falling steps
  task automatic load_axis(input int ax, input bit wide, input bit noise);
    longint v, step;
    v = wide ? -64'sd2147483648 + $urandom_range(0, 1 << 20)
             : longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    for (int k = 0; k < AXIS_NODES; k++) begin
      node_write(ax, k, v);
      step = wide ? $urandom_range(1, (1 << 27) - 1) : $urandom_range(1, 1 << 18);
      if (noise && $urandom_range(0, 3) == 0) step = -longint'($urandom_range(0, 1000));
      v = v + step;
    end
  endtask

  function automatic logic signed [31:0] pick_coord(input int ax);
    longint lo, hi, span, r;
    lo = node_shadow[ax][0];
    hi = node_shadow[ax][cur_cnt[ax]-1];
    case ($urandom_range(0, 9))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return clip32(node_shadow[ax][$urandom_range(0, cur_cnt[ax] - 1)]);
      3: return clip32(lo - $urandom_range(0, 1000));
      4: return clip32(hi + $urandom_range(0, 1000));
      default: begin
        span = hi - lo;
        if (span <= 0) return clip32(lo);
        r = longint'({$urandom, $urandom} & 64'h3fffffffffffffff) % (span + 1);
        return clip32(lo + r);
      end
    endcase
  endfunction

  task automatic rand_lookup();
    logic signed [31:0] c [NUM_AXES];
    foreach (c[a]) c[a] = pick_coord(a);
    lookup_at(c);
  endtask

  // One random beat, weighted toward lookups
  task automatic rand_beat();
    req_item_t it;
    int        r, ax, ni;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      rand_lookup();
    end else if (r < 75) begin
      entry_write($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
    end else if (r < 85) begin
      ax = $urandom_range(0, NUM_AXES - 1);
      ni = $urandom_range(0, AXIS_NODES - 1);
      node_write(ax, ni, node_shadow[ax][ni] + $urandom_range(0, 200) - 100);
    end else if (r < 92) begin
      node_write($urandom_range(NUM_AXES, 7), $urandom_range(0, AXIS_NODES - 1), $urandom);
    end else if (r < 96) begin
      it = rand_item();
      send_item(it);
    end else begin
      node_write($urandom_range(0, NUM_AXES - 1), $urandom_range(0, AXIS_NODES - 1),
                 longint'($signed($urandom)));
    end
  endtask

  int                 phase_cfg [8][NUM_AXES];
  logic signed [31:0] dc [NUM_AXES];

  initial begin
    phase_cfg = '{'{16, 16, 16, 16, 16}, '{2, 2, 2, 2, 2}, '{0, 1, 17, 31, 3},
                  '{4, 3, 5, 2, 6}, '{8, 8, 4, 2, 2}, '{16, 2, 2, 2, 8},
                  '{3, 16, 2, 5, 2}, '{6, 4, 3, 3, 2}};
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    send_gaps = 1'b0;
    rsp_gaps  = 1'b0;
    hold_rsp  = 1'b0;
    foreach (cur_cnt[a]) cur_cnt[a] = 2;
    foreach (node_shadow[a, k]) node_shadow[a][k] = 0;
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_NONE;
    req_if.axis_select  = '0;
    req_if.node_index   = '0;
    req_if.node_value   = '0;
    req_if.entry_index  = '0;
    req_if.entry_first  = '0;
    req_if.entry_second = '0;
    req_if.query_c1     = '0;
    req_if.query_c2     = '0;
    req_if.query_c3     = '0;
    req_if.query_c4     = '0;
    req_if.query_c5     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every node and every table entry so no lookup reads an unwritten one
    for (int a = 0; a < NUM_AXES; a++) load_axis(a, 1'b0, 1'b0);
    for (int e = 0; e < TABLE_DEPTH; e++) entry_write(e, $urandom, $urandom);

    // Directed: clamp at both ends, exact nodes, extreme entries, ignored beats
    entry_write(0, 32'h7fffffff, 32'h80000000);
    entry_write(TABLE_DEPTH - 1, 32'h80000000, 32'h7fffffff);
    foreach (dc[a]) dc[a] = 32'sh80000000;
    lookup_at(dc);
    foreach (dc[a]) dc[a] = 32'sh7fffffff;
    lookup_at(dc);
    foreach (dc[a]) dc[a] = clip32(node_shadow[a][0]);
    lookup_at(dc);
    foreach (dc[a]) dc[a] = clip32(node_shadow[a][1]);
    lookup_at(dc);
    foreach (dc[a]) dc[a] = clip32((node_shadow[a][0] + node_shadow[a][1]) / 2);
    lookup_at(dc);
    node_write(7, 3, $urandom);
    node_write(5, 0, $urandom);
    node_write(0, AXIS_NODES - 1, 32'sh7fffffff);
    lookup_at(dc);
    begin
      req_item_t it;
      it = rand_item();
      send_item(it);
    end
    // Degenerate cell: a flat first cell on axis one
    node_write(0, 1, node_shadow[0][0]);
    lookup_at(dc);
    node_write(0, 1, node_shadow[0][0] + 5000);
    drain();
    cfg_write(5, $urandom);
    cfg_write(7, 31);
    set_counts(16, 16, 16, 16, 16);
    foreach (dc[a]) dc[a] = 32'sh7fffffff;
    lookup_at(dc);
    foreach (dc[a]) dc[a] = 32'sh80000000;
    lookup_at(dc);
    rand_lookup();

    // Random phases over several node counts and node layouts
    for (int p = 0; p < 8; p++) begin
      set_counts(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3],
                 phase_cfg[p][4]);
      for (int a = 0; a < NUM_AXES; a++)
        load_axis(a, (p % 3) == 1, $urandom_range(0, 4) == 0);
      send_gaps = (p < 7);
      rsp_gaps  = (p < 7);
      for (int k = 0; k < 170; k++) begin
        if (p == 2 && k == 40) hold_rsp = 1'b1;
        if (p == 3 && k == 50) drain();
        rand_beat();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("[table_interp_5d_core] OK");
    end else begin
      $display("[table_interp_5d_core] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
src/tbl5d_pkg.sv
src/tbl5d_if.sv
src/tbl5d_lerp.sv
src/tbl5d_locate.sv
src/table_interp_5d_core.sv
verif/tbl5d_checker.sv
verif/tb_table_interp_5d_core.sv
